[sv/gfp_pkg.sv]
package gfp_pkg;

  localparam int unsigned PaletteEntries = 256;

  typedef enum logic [1:0] {
    ACT_PALETTE = 2'd0,
    ACT_START   = 2'd1,
    ACT_PIXEL   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DROP   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_CANVAS_WIDTH  = 1'b0,
    CFG_CANVAS_HEIGHT = 1'b1
  } cfg_index_e;

  // interlace pass row offsets and steps
  localparam logic [3:0] PassOffset [4] = '{4'd0, 4'd4, 4'd2, 4'd1};
  localparam logic [3:0] PassStep   [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

  // result stage contents, color comes from the palette read register
  typedef struct packed {
    kind_e       kind;
    logic        write_enable;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        color_en;
    logic        last_pixel;
  } stage_t;

  typedef struct packed {
    kind_e       kind;
    logic        write_enable;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
  } result_t;

endpackage

[sv/gif_frame_pixel_placer.sv]
// GIF frame pixel placer.
// Input channel (in_valid_i/in_ready_o) carries one item per action:
// palette write, image start (rectangle, interlace, transparency) or pixel.
// Output channel (out_valid_o/out_ready_i) carries at most one result per
// item: pixel write, image accepted/rejected or pixel dropped. Palette
// writes and unused action codes give no result.
// Config port (cfg_we_i, cfg_index_i, cfg_data_i) sets canvas width and
// height; write only while idle.
// An accepted item passes through the result stage (counter update plus
// registered palette read) and then the output buffer before out_valid_o.
// Throughput: one item per cycle while in_ready_o is high; the palette read
// port and the row/pass update both finish in the cycle the item is taken.
// A two-entry output buffer lets input keep flowing while a result waits;
// in_ready_o drops only when both buffer entries and the result stage are
// full, so a stalled receiver backs up the input after three results.
// Reset: canvas 8x8, no active image, counters cleared. Palette contents
// are unknown until written; reset needs no clearing pass.
module gif_frame_pixel_placer import gfp_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  color_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [15:0] img_left_i,
  input  logic [15:0] img_top_i,
  input  logic [15:0] img_width_i,
  input  logic [15:0] img_height_i,
  input  logic        interlaced_i,
  input  logic        use_transparency_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        write_enable_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        last_pixel_o
);

  logic        accept, stage_valid, move, skid_full;
  logic        pal_we, pal_re;
  logic [23:0] pal_rdata;
  stage_t      stage;
  result_t     res, res_out;

  // result stage may only advance when the buffer has room
  assign move       = stage_valid && !skid_full;
  assign in_ready_o = !stage_valid || !skid_full;
  assign accept     = in_valid_i && in_ready_o;
  assign pal_we     = accept && (action_i == ACT_PALETTE);
  assign pal_re     = accept && (action_i == ACT_PIXEL);

  gfp_palette #(.ENTRIES(PALETTE_ENTRIES)) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .re_i    (pal_re),
    .index_i (color_index_i),
    .wdata_i ({red_i, green_i, blue_i}),
    .rdata_o (pal_rdata)
  );

  gfp_ctrl #(.ENTRIES(PALETTE_ENTRIES)) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .accept_i           (accept),
    .action_i           (action_i),
    .color_index_i      (color_index_i),
    .img_left_i         (img_left_i),
    .img_top_i          (img_top_i),
    .img_width_i        (img_width_i),
    .img_height_i       (img_height_i),
    .interlaced_i       (interlaced_i),
    .use_transparency_i (use_transparency_i),
    .move_i             (move),
    .stage_valid_o      (stage_valid),
    .stage_o            (stage)
  );

  // transparent or out-of-range pixels carry black
  always_comb begin
    res.kind         = stage.kind;
    res.write_enable = stage.write_enable;
    res.pos_x        = stage.pos_x;
    res.pos_y        = stage.pos_y;
    res.last_pixel   = stage.last_pixel;
    res.red          = stage.color_en ? pal_rdata[23:16] : 8'd0;
    res.green        = stage.color_en ? pal_rdata[15:8]  : 8'd0;
    res.blue         = stage.color_en ? pal_rdata[7:0]   : 8'd0;
  end

  gfp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (move),
    .data_i  (res),
    .full_o  (skid_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign kind_o         = res_out.kind;
  assign write_enable_o = res_out.write_enable;
  assign pos_x_o        = res_out.pos_x;
  assign pos_y_o        = res_out.pos_y;
  assign out_red_o      = res_out.red;
  assign out_green_o    = res_out.green;
  assign out_blue_o     = res_out.blue;
  assign last_pixel_o   = res_out.last_pixel;

`ifndef NO_ASSERTIONS
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_valid && skid_full)) else $error("input stalled without cause");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_START || action_i == ACT_PIXEL)) |=> stage_valid)
    else $error("result lost after accept");
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_PALETTE || action_i == ACT_NONE)) |=> !move)
    else $error("result from silent action");
  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_PIXEL) |-> (!write_enable_o && !last_pixel_o))
    else $error("non-pixel result carries pixel flags");
`endif

endmodule

[sv/gfp_palette.sv]
module gfp_palette import gfp_pkg::*; #(
  parameter int unsigned ENTRIES = PaletteEntries
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic        re_i,
  input  logic [7:0]  index_i,
  input  logic [23:0] wdata_i,
  output logic [23:0] rdata_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0] EntriesW = 9'(ENTRIES);

  logic [23:0] mem_q [ENTRIES];
  logic [23:0] rdata_q;
  logic        in_range;
  logic [AW-1:0] addr;

  assign in_range = {1'b0, index_i} < EntriesW;
  assign addr     = index_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i && in_range) begin
      mem_q[addr] <= wdata_i;
    end
  end

  // read register holds while the result stage is stalled
  always_ff @(posedge clk_i) begin
    if (re_i && in_range) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/gfp_ctrl.sv]
module gfp_ctrl import gfp_pkg::*; #(
  parameter int unsigned ENTRIES = PaletteEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  color_index_i,
  input  logic [15:0] img_left_i,
  input  logic [15:0] img_top_i,
  input  logic [15:0] img_width_i,
  input  logic [15:0] img_height_i,
  input  logic        interlaced_i,
  input  logic        use_transparency_i,
  input  logic        move_i,
  output logic        stage_valid_o,
  output stage_t      stage_o
);

  localparam logic [8:0] EntriesW = 9'(ENTRIES);

  logic [15:0] canvas_w_q, canvas_h_q;
  logic [15:0] left_q, top_q, width_q, height_q;
  logic [15:0] left_d, top_d, width_d, height_d;
  logic        ilace_q, ilace_d, skip_en_q, skip_en_d;
  logic [7:0]  skip_idx_q, skip_idx_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [1:0]  pass_q, pass_d;
  logic        active_q, active_d;
  logic        stage_valid_q, stage_valid_d;
  stage_t      stage_q, stage_d;

  logic [16:0] sum_x, sum_y, col_inc, row_inc, r;
  logic        reject, wrap, transparent, fin, done;
  logic [1:0]  p;
  logic [15:0] row_next;
  logic [1:0]  pass_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= 16'd8;
      canvas_h_q <= 16'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next row position, up to three pass changes chained
  always_comb begin
    row_inc   = {1'b0, row_q} + 17'd1;
    r         = {1'b0, row_q} + 17'(PassStep[pass_q]);
    p         = pass_q;
    fin       = 1'b0;
    done      = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!fin) begin
        if (r < {1'b0, height_q}) begin
          fin = 1'b1;
        end else if (p == 2'd3) begin
          fin  = 1'b1;
          done = 1'b1;
          r    = '0;
        end else begin
          p = p + 2'd1;
          r = 17'(PassOffset[p]);
        end
      end
    end
    if (ilace_q) begin
      row_next  = r[15:0];
      pass_next = p;
    end else begin
      row_next  = row_inc[15:0];
      pass_next = pass_q;
      done      = row_inc >= {1'b0, height_q};
    end
  end

  always_comb begin
    sum_x       = {1'b0, img_left_i} + {1'b0, img_width_i};
    sum_y       = {1'b0, img_top_i} + {1'b0, img_height_i};
    reject      = (sum_x > {1'b0, canvas_w_q}) || (sum_y > {1'b0, canvas_h_q});
    col_inc     = {1'b0, col_q} + 17'd1;
    wrap        = col_inc >= {1'b0, width_q};
    transparent = skip_en_q && (color_index_i == skip_idx_q);

    left_d = left_q; top_d = top_q; width_d = width_q; height_d = height_q;
    ilace_d = ilace_q; skip_en_d = skip_en_q; skip_idx_d = skip_idx_q;
    col_d = col_q; row_d = row_q; pass_d = pass_q; active_d = active_q;
    stage_d = '0;
    stage_d.kind = KIND_DROP;
    stage_valid_d = stage_valid_q && !move_i;

    if (accept_i) begin
      stage_valid_d = 1'b0;
      case (action_e'(action_i))
        ACT_START: begin
          stage_valid_d = 1'b1;
          if (reject) begin
            active_d     = 1'b0;
            stage_d.kind = KIND_REJECT;
          end else begin
            left_d       = img_left_i;
            top_d        = img_top_i;
            width_d      = img_width_i;
            height_d     = img_height_i;
            ilace_d      = interlaced_i;
            skip_en_d    = use_transparency_i;
            skip_idx_d   = color_index_i;
            col_d        = '0;
            row_d        = '0;
            pass_d       = '0;
            active_d     = (img_width_i != '0) && (img_height_i != '0);
            stage_d.kind = KIND_ACCEPT;
          end
        end
        ACT_PIXEL: begin
          stage_valid_d = 1'b1;
          if (active_q) begin
            stage_d.kind         = KIND_PIXEL;
            stage_d.pos_x        = left_q + col_q;
            stage_d.pos_y        = top_q + row_q;
            stage_d.write_enable = !transparent;
            stage_d.color_en     = !transparent && ({1'b0, color_index_i} < EntriesW);
            if (wrap) begin
              col_d  = '0;
              row_d  = row_next;
              pass_d = pass_next;
              if (done) begin
                active_d           = 1'b0;
                stage_d.last_pixel = 1'b1;
              end
            end else begin
              col_d = col_inc[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0; top_q <= '0; width_q <= '0; height_q <= '0;
      ilace_q <= 1'b0; skip_en_q <= 1'b0; skip_idx_q <= '0;
      col_q <= '0; row_q <= '0; pass_q <= '0;
      active_q <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      left_q <= left_d; top_q <= top_d; width_q <= width_d; height_q <= height_d;
      ilace_q <= ilace_d; skip_en_q <= skip_en_d; skip_idx_q <= skip_idx_d;
      col_q <= col_d; row_q <= row_d; pass_q <= pass_d;
      active_q <= active_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

[sv/gfp_skid.sv]
module gfp_skid import gfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t     mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("skid count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full skid");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && pop && !push_i) |=> !valid_o) else $error("skid drain mismatch");
`endif

endmodule
